// ----- sv/jsu_pkg.sv -----
// Shared types and constants of the JSON string unescape unit.
package jsu_pkg;

  // Decoder phase
  typedef enum logic [2:0] {
    PH_WAIT     = 3'd0,
    PH_BODY     = 3'd1,
    PH_ESC      = 3'd2,
    PH_HEX      = 3'd3,
    PH_PAIR_BS  = 3'd4,
    PH_PAIR_U   = 3'd5,
    PH_PAIR_HEX = 3'd6
  } phase_e;

  // Main part of one queued command
  typedef enum logic [2:0] {
    MK_NONE = 3'd0,
    MK_BYTE = 3'd1,
    MK_CP   = 3'd2,
    MK_DONE = 3'd3,
    MK_ERR  = 3'd4
  } main_e;

  // Result kinds on the output
  localparam logic [1:0] RK_BYTE = 2'd0;
  localparam logic [1:0] RK_DONE = 2'd1;
  localparam logic [1:0] RK_ERR  = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_EXPECT    = 3'd1;
  localparam logic [2:0] ERR_TRUNC_U   = 3'd2;
  localparam logic [2:0] ERR_BAD_U     = 3'd3;
  localparam logic [2:0] ERR_BAD_ESC   = 3'd4;
  localparam logic [2:0] ERR_UNTERM    = 3'd5;

  // Characters
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  // Surrogate bounds
  localparam logic [15:0] HI_SUR_MIN = 16'hD800;
  localparam logic [15:0] HI_SUR_MAX = 16'hDBFF;
  localparam logic [15:0] LO_SUR_MIN = 16'hDC00;
  localparam logic [15:0] LO_SUR_MAX = 16'hDFFF;

  // One front-to-back command: optional held surrogate flush, then main part
  typedef struct packed {
    logic        flush;
    logic [15:0] flush_cp;
    main_e       kind;
    logic [20:0] cp;
    logic [2:0]  err;
  } cmd_t;

endpackage

// ----- sv/json_string_unescape_utf8_unit.sv -----
// Top level of the JSON string unescape unit (text bytes in, UTF-8 results out).
//
//  Port group  Dir  Payload
//  s_axis      in   tdata[7:0] in_byte, tuser[0] text_end
//  m_axis      out  tdata out_byte/error_code, tuser result_kind, tlast run_last
//
// One text byte is accepted per cycle while the command queue has room.
// The emitter sends the results of an item one after another, so an item with n
// results holds the emitter until all n have left (at most six, for a flushed
// surrogate followed by a three-byte character); the queue absorbs bursts.
// Reset is asynchronous; the decoder returns to waiting for a quote.
// A stalled m_axis holds the output register; s_axis stalls when the queue fills.
module json_string_unescape_utf8_unit #(
  parameter int QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic [0:0]  s_axis_tuser,   // [0] text_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] error_code
  output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
  output logic        m_axis_tlast
);
  import jsu_pkg::*;

  logic       push, full, pop, cmd_valid;
  cmd_t       push_cmd, head_cmd;
  logic [1:0] result_kind;
  logic [7:0] out_byte;
  logic [2:0] error_code;

  assign s_axis_tready = !full;

  jsu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_i (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .text_end_i (s_axis_tuser[0]),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  jsu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (cmd_valid),
    .head_o      (head_cmd)
  );

  jsu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (head_cmd),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .result_kind_o (result_kind),
    .out_byte_o    (out_byte),
    .error_code_o  (error_code),
    .run_last_o    (m_axis_tlast)
  );

  assign m_axis_tuser = result_kind;
  assign m_axis_tdata = {5'b00000, error_code, out_byte};

endmodule

// ----- sv/jsu_front.sv -----
// Front end: accepts text bytes, runs the string decoder and issues commands.
module jsu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  logic [7:0]    in_byte_i,
  input  logic          text_end_i,
  output logic          push_o,
  output jsu_pkg::cmd_t cmd_o
);
  import jsu_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] acc_q, acc_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        bad_q, bad_d;
  logic [15:0] held_q, held_d;

  logic        accept;
  logic [3:0]  dig;
  logic        dig_ok;
  logic [15:0] acc_new;
  logic [2:0]  cnt_new;
  logic        bad_new;
  logic        hex_full;

  // body byte outcome
  main_e       body_kind;
  phase_e      body_next;
  // escape byte outcome
  main_e       esc_kind;
  logic [7:0]  esc_val;
  phase_e      esc_next;
  logic        esc_start;

  assign accept = in_valid_i && in_ready_i;

  always_comb begin
    dig    = 4'd0;
    dig_ok = 1'b1;
    if (in_byte_i >= 8'h30 && in_byte_i <= 8'h39) begin
      dig = 4'(in_byte_i - 8'h30);
    end else if (in_byte_i >= 8'h61 && in_byte_i <= 8'h66) begin
      dig = 4'(in_byte_i - 8'h57);
    end else if (in_byte_i >= 8'h41 && in_byte_i <= 8'h46) begin
      dig = 4'(in_byte_i - 8'h37);
    end else begin
      dig_ok = 1'b0;
    end
  end

  assign acc_new  = dig_ok ? {acc_q[11:0], dig} : acc_q;
  assign bad_new  = bad_q | ~dig_ok;
  assign cnt_new  = cnt_q + 3'd1;
  assign hex_full = (cnt_new >= 3'd4);

  always_comb begin
    body_kind = MK_BYTE;
    body_next = PH_BODY;
    if (in_byte_i == CH_QUOTE) begin
      body_kind = MK_DONE;
      body_next = PH_WAIT;
    end else if (in_byte_i == CH_BSLASH) begin
      body_kind = MK_NONE;
      body_next = PH_ESC;
    end
  end

  always_comb begin
    esc_kind  = MK_BYTE;
    esc_val   = in_byte_i;
    esc_next  = PH_BODY;
    esc_start = 1'b0;
    case (in_byte_i)
      CH_QUOTE, CH_BSLASH, CH_SLASH: esc_val = in_byte_i;
      CH_B: esc_val = 8'h08;
      CH_F: esc_val = 8'h0C;
      CH_N: esc_val = 8'h0A;
      CH_R: esc_val = 8'h0D;
      CH_T: esc_val = 8'h09;
      CH_U: begin
        esc_kind  = MK_NONE;
        esc_next  = PH_HEX;
        esc_start = 1'b1;
      end
      default: begin
        esc_kind = MK_ERR;
        esc_next = PH_WAIT;
      end
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    bad_d   = bad_q;
    held_d  = held_q;
    cmd_o   = '0;
    cmd_o.kind = MK_NONE;
    cmd_o.flush_cp = held_q;
    case (phase_q)
      PH_BODY: begin
        if (text_end_i) begin
          cmd_o.kind = MK_ERR;
          cmd_o.err  = ERR_UNTERM;
          phase_d    = PH_WAIT;
        end else begin
          cmd_o.kind = body_kind;
          cmd_o.cp   = 21'(in_byte_i);
          phase_d    = body_next;
        end
      end
      PH_ESC: begin
        if (text_end_i) begin
          cmd_o.kind = MK_ERR;
          cmd_o.err  = ERR_UNTERM;
          phase_d    = PH_WAIT;
        end else begin
          cmd_o.kind = esc_kind;
          cmd_o.cp   = 21'(esc_val);
          cmd_o.err  = ERR_BAD_ESC;
          phase_d    = esc_next;
        end
      end
      PH_HEX: begin
        if (text_end_i) begin
          cmd_o.kind = MK_ERR;
          cmd_o.err  = ERR_TRUNC_U;
          phase_d    = PH_WAIT;
        end else begin
          acc_d = acc_new;
          bad_d = bad_new;
          cnt_d = cnt_new;
          if (hex_full) begin
            if (bad_new) begin
              cmd_o.kind = MK_ERR;
              cmd_o.err  = ERR_BAD_U;
              phase_d    = PH_WAIT;
            end else if (acc_new >= HI_SUR_MIN && acc_new <= HI_SUR_MAX) begin
              held_d  = acc_new;
              phase_d = PH_PAIR_BS;
            end else begin
              cmd_o.kind = MK_CP;
              cmd_o.cp   = 21'(acc_new);
              phase_d    = PH_BODY;
            end
          end
        end
      end
      PH_PAIR_BS: begin
        if (!text_end_i && in_byte_i == CH_BSLASH) begin
          phase_d = PH_PAIR_U;
        end else begin
          cmd_o.flush = 1'b1;
          if (text_end_i) begin
            cmd_o.kind = MK_ERR;
            cmd_o.err  = ERR_UNTERM;
            phase_d    = PH_WAIT;
          end else begin
            cmd_o.kind = body_kind;
            cmd_o.cp   = 21'(in_byte_i);
            phase_d    = body_next;
          end
        end
      end
      PH_PAIR_U: begin
        if (!text_end_i && in_byte_i == CH_U) begin
          phase_d = PH_PAIR_HEX;
          acc_d   = '0;
          cnt_d   = '0;
          bad_d   = 1'b0;
        end else begin
          cmd_o.flush = 1'b1;
          if (text_end_i) begin
            cmd_o.kind = MK_ERR;
            cmd_o.err  = ERR_UNTERM;
            phase_d    = PH_WAIT;
          end else begin
            cmd_o.kind = esc_kind;
            cmd_o.cp   = 21'(esc_val);
            cmd_o.err  = ERR_BAD_ESC;
            phase_d    = esc_next;
          end
        end
      end
      PH_PAIR_HEX: begin
        if (text_end_i) begin
          cmd_o.flush = 1'b1;
          cmd_o.kind  = MK_ERR;
          cmd_o.err   = ERR_TRUNC_U;
          phase_d     = PH_WAIT;
        end else begin
          acc_d = acc_new;
          bad_d = bad_new;
          cnt_d = cnt_new;
          if (hex_full) begin
            if (bad_new) begin
              cmd_o.flush = 1'b1;
              cmd_o.kind  = MK_ERR;
              cmd_o.err   = ERR_BAD_U;
              phase_d     = PH_WAIT;
            end else if (acc_new >= LO_SUR_MIN && acc_new <= LO_SUR_MAX) begin
              // join the pair into one supplementary code point
              cmd_o.kind = MK_CP;
              cmd_o.cp   = 21'h10000 + {1'b0, held_q[9:0], acc_new[9:0]};
              phase_d    = PH_BODY;
            end else if (acc_new >= HI_SUR_MIN && acc_new <= HI_SUR_MAX) begin
              cmd_o.flush = 1'b1;
              held_d      = acc_new;
              phase_d     = PH_PAIR_BS;
            end else begin
              cmd_o.flush = 1'b1;
              cmd_o.kind  = MK_CP;
              cmd_o.cp    = 21'(acc_new);
              phase_d     = PH_BODY;
            end
          end
        end
      end
      default: begin
        if (text_end_i || in_byte_i != CH_QUOTE) begin
          cmd_o.kind = MK_ERR;
          cmd_o.err  = ERR_EXPECT;
          phase_d    = PH_WAIT;
        end else begin
          phase_d = PH_BODY;
        end
      end
    endcase
    if (esc_start && !text_end_i && phase_q == PH_ESC) begin
      acc_d = '0;
      cnt_d = '0;
      bad_d = 1'b0;
    end
  end

  assign push_o = accept && (cmd_o.flush || cmd_o.kind != MK_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      acc_q   <= '0;
      cnt_q   <= '0;
      bad_q   <= 1'b0;
      held_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      bad_q   <= bad_d;
      held_q  <= held_d;
    end
  end

endmodule

// ----- sv/jsu_queue.sv -----
// Command queue between the decoder front end and the byte emitter.
module jsu_queue #(
  parameter int Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jsu_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output jsu_pkg::cmd_t head_o
);
  import jsu_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    next_ptr = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue pop while empty");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + CntW'(1))
    else $error("queue count did not advance on push");

endmodule

// ----- sv/jsu_back.sv -----
// Back end: expands queued commands into UTF-8 bytes, completion and error results.
module jsu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  jsu_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    result_kind_o,
  output logic [7:0]    out_byte_o,
  output logic [2:0]    error_code_o,
  output logic          run_last_o
);
  import jsu_pkg::*;

  logic [2:0] idx_q;
  logic       valid_q;
  logic [1:0] kind_q;
  logic [7:0] byte_q;
  logic [2:0] err_q;
  logic       last_q;

  logic       slot_free;
  logic [2:0] main_len;
  logic [2:0] total;
  logic [2:0] flush_len;
  logic [1:0] pos;
  logic       in_flush;
  logic [1:0] res_kind;
  logic [7:0] res_byte;
  logic [2:0] res_err;
  logic       res_last;

  assign slot_free = !valid_q || out_ready_i;
  assign flush_len = cmd_i.flush ? 3'd3 : 3'd0;
  assign in_flush  = cmd_i.flush && (idx_q < 3'd3);
  assign pos       = in_flush ? idx_q[1:0] : 2'(idx_q - flush_len);

  always_comb begin
    case (cmd_i.kind)
      MK_BYTE, MK_DONE, MK_ERR: main_len = 3'd1;
      MK_CP: begin
        if (cmd_i.cp < 21'h80) begin
          main_len = 3'd1;
        end else if (cmd_i.cp < 21'h800) begin
          main_len = 3'd2;
        end else if (cmd_i.cp < 21'h10000) begin
          main_len = 3'd3;
        end else begin
          main_len = 3'd4;
        end
      end
      default: main_len = 3'd0;
    endcase
  end

  assign total    = flush_len + main_len;
  assign res_last = (idx_q == total - 3'd1);

  always_comb begin
    res_kind = RK_BYTE;
    res_byte = 8'h00;
    res_err  = ERR_NONE;
    if (in_flush) begin
      // held surrogate always takes the three-byte form
      case (pos)
        2'd0:    res_byte = {4'hE, cmd_i.flush_cp[15:12]};
        2'd1:    res_byte = {2'b10, cmd_i.flush_cp[11:6]};
        default: res_byte = {2'b10, cmd_i.flush_cp[5:0]};
      endcase
    end else begin
      case (cmd_i.kind)
        MK_DONE: res_kind = RK_DONE;
        MK_ERR: begin
          res_kind = RK_ERR;
          res_err  = cmd_i.err;
        end
        MK_CP: begin
          case (main_len)
            3'd1: res_byte = cmd_i.cp[7:0];
            3'd2: begin
              res_byte = (pos == 2'd0) ? {3'b110, cmd_i.cp[10:6]}
                                       : {2'b10, cmd_i.cp[5:0]};
            end
            3'd3: begin
              case (pos)
                2'd0:    res_byte = {4'hE, cmd_i.cp[15:12]};
                2'd1:    res_byte = {2'b10, cmd_i.cp[11:6]};
                default: res_byte = {2'b10, cmd_i.cp[5:0]};
              endcase
            end
            default: begin
              case (pos)
                2'd0:    res_byte = {5'b11110, cmd_i.cp[20:18]};
                2'd1:    res_byte = {2'b10, cmd_i.cp[17:12]};
                2'd2:    res_byte = {2'b10, cmd_i.cp[11:6]};
                default: res_byte = {2'b10, cmd_i.cp[5:0]};
              endcase
            end
          endcase
        end
        default: res_byte = cmd_i.cp[7:0];
      endcase
    end
  end

  assign pop_o = cmd_valid_i && slot_free && res_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else if (slot_free) begin
      valid_q <= cmd_valid_i;
      if (cmd_valid_i) begin
        idx_q <= res_last ? 3'd0 : idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free && cmd_valid_i) begin
      kind_q <= res_kind;
      byte_q <= res_byte;
      err_q  <= res_err;
      last_q <= res_last;
    end
  end

  assign out_valid_o   = valid_q;
  assign result_kind_o = kind_q;
  assign out_byte_o    = byte_q;
  assign error_code_o  = err_q;
  assign run_last_o    = last_q;

  a_idx_in_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i |-> idx_q < total)
    else $error("result index beyond command length");

  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_valid_i |-> idx_q == 3'd0)
    else $error("result index not rewound with queue empty");

  a_err_coded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && kind_q == RK_ERR) |-> (err_q != ERR_NONE && last_q))
    else $error("error result without code or not last");

endmodule

// ----- bench/jsu_result_checker.sv -----
// Result checker for the JSON string unescape unit: predicts UTF-8 results per request.
`timescale 1ns / 100ps

module jsu_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic [0:0]  s_axis_tuser,   // [0] text_end
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] error_code
  input  logic [1:0]  m_axis_tuser,   // [1:0] result_kind
  input  logic        m_axis_tlast,
  output int          fail_cnt_o,
  output int          pending_o
);
  import jsu_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [2:0] err;
    logic       last;
  } utf8_result_t;

  utf8_result_t utf8_due_q[$];

  // Decoder state
  phase_e      phase;
  logic [15:0] hex_acc;
  logic [2:0]  digit_cnt;
  logic        hex_bad;
  logic [15:0] high_cp;
  logic        high_held;

  function automatic void push_result(logic [1:0] k, logic [7:0] d, logic [2:0] e);
    utf8_due_q.push_back({k, d, e, 1'b0});
  endfunction

  function automatic void clear_state();
    phase     = PH_WAIT;
    hex_acc   = '0;
    digit_cnt = '0;
    hex_bad   = 1'b0;
    high_cp   = '0;
    high_held = 1'b0;
  endfunction

  function automatic void fail_with(logic [2:0] code);
    push_result(RK_ERR, 8'h00, code);
    clear_state();
  endfunction

  function automatic void emit_utf8(logic [20:0] cp);
    if (cp < 21'h80) begin
      push_result(RK_BYTE, cp[7:0], ERR_NONE);
    end else if (cp < 21'h800) begin
      push_result(RK_BYTE, {3'b110, cp[10:6]}, ERR_NONE);
      push_result(RK_BYTE, {2'b10, cp[5:0]}, ERR_NONE);
    end else if (cp < 21'h10000) begin
      push_result(RK_BYTE, {4'b1110, cp[15:12]}, ERR_NONE);
      push_result(RK_BYTE, {2'b10, cp[11:6]}, ERR_NONE);
      push_result(RK_BYTE, {2'b10, cp[5:0]}, ERR_NONE);
    end else begin
      push_result(RK_BYTE, {5'b11110, cp[20:18]}, ERR_NONE);
      push_result(RK_BYTE, {2'b10, cp[17:12]}, ERR_NONE);
      push_result(RK_BYTE, {2'b10, cp[11:6]}, ERR_NONE);
      push_result(RK_BYTE, {2'b10, cp[5:0]}, ERR_NONE);
    end
  endfunction

  // Accumulate one \u digit; a non-hex byte sets the bad flag and keeps the accumulator but still counts
  function automatic void take_digit(logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) begin
      hex_acc = {hex_acc[11:0], 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      hex_acc = {hex_acc[11:0], 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      hex_acc = {hex_acc[11:0], 4'(b - 8'h37)};
    end else begin
      hex_bad = 1'b1;
    end
    digit_cnt = digit_cnt + 3'd1;
  endfunction

  function automatic void start_hex(phase_e ph);
    phase     = ph;
    hex_acc   = '0;
    digit_cnt = '0;
    hex_bad   = 1'b0;
  endfunction

  function automatic void flush_high();
    emit_utf8({5'b0, high_cp});
    high_cp   = '0;
    high_held = 1'b0;
    phase     = PH_BODY;
  endfunction

  function automatic void finish_value(logic [15:0] v);
    if (v >= HI_SUR_MIN && v <= HI_SUR_MAX) begin
      high_cp   = v;
      high_held = 1'b1;
      phase     = PH_PAIR_BS;
    end else begin
      emit_utf8({5'b0, v});
      phase = PH_BODY;
    end
  endfunction

  function automatic void body_byte(logic [7:0] b);
    if (b == CH_QUOTE) begin
      push_result(RK_DONE, 8'h00, ERR_NONE);
      clear_state();
    end else if (b == CH_BSLASH) begin
      phase = PH_ESC;
    end else begin
      push_result(RK_BYTE, b, ERR_NONE);
    end
  endfunction

  function automatic void esc_byte(logic [7:0] b);
    logic [7:0] c;
    c = 8'h00;
    case (b)
      CH_QUOTE, CH_BSLASH, CH_SLASH: c = b;
      CH_B: c = 8'h08;
      CH_F: c = 8'h0C;
      CH_N: c = 8'h0A;
      CH_R: c = 8'h0D;
      CH_T: c = 8'h09;
      CH_U: begin
        start_hex(PH_HEX);
        return;
      end
      default: begin
        fail_with(ERR_BAD_ESC);
        return;
      end
    endcase
    push_result(RK_BYTE, c, ERR_NONE);
    phase = PH_BODY;
  endfunction

  // Advance the decoder by one request and queue the results it causes
  function automatic void decode_text_byte(logic [7:0] b, logic fin);
    utf8_result_t r;
    int           n_before;
    logic [15:0]  v;
    logic [20:0]  cp;
    n_before = utf8_due_q.size();
    case (phase)
      PH_BODY: begin
        if (fin) fail_with(ERR_UNTERM);
        else body_byte(b);
      end
      PH_ESC: begin
        if (fin) fail_with(ERR_UNTERM);
        else esc_byte(b);
      end
      PH_HEX: begin
        if (fin) begin
          fail_with(ERR_TRUNC_U);
        end else begin
          take_digit(b);
          if (digit_cnt >= 3'd4) begin
            if (hex_bad) fail_with(ERR_BAD_U);
            else finish_value(hex_acc);
          end
        end
      end
      PH_PAIR_BS: begin
        if (!fin && b == CH_BSLASH) begin
          phase = PH_PAIR_U;
        end else begin
          flush_high();
          if (fin) fail_with(ERR_UNTERM);
          else body_byte(b);
        end
      end
      PH_PAIR_U: begin
        if (!fin && b == CH_U) begin
          start_hex(PH_PAIR_HEX);
        end else begin
          flush_high();
          phase = PH_ESC;
          if (fin) fail_with(ERR_UNTERM);
          else esc_byte(b);
        end
      end
      PH_PAIR_HEX: begin
        if (fin) begin
          flush_high();
          fail_with(ERR_TRUNC_U);
        end else begin
          take_digit(b);
          if (digit_cnt >= 3'd4) begin
            if (hex_bad) begin
              flush_high();
              fail_with(ERR_BAD_U);
            end else if (hex_acc >= LO_SUR_MIN && hex_acc <= LO_SUR_MAX) begin
              cp = 21'h10000 + ({5'b0, 16'(high_cp - HI_SUR_MIN)} << 10)
                   + {5'b0, 16'(hex_acc - LO_SUR_MIN)};
              high_cp   = '0;
              high_held = 1'b0;
              emit_utf8(cp);
              phase = PH_BODY;
            end else begin
              // lookahead failed: flush the held surrogate, then decode the new value
              v = hex_acc;
              flush_high();
              finish_value(v);
            end
          end
        end
      end
      default: begin
        if (fin || b != CH_QUOTE) fail_with(ERR_EXPECT);
        else phase = PH_BODY;
      end
    endcase
    if (utf8_due_q.size() > n_before) begin
      r = utf8_due_q.pop_back();
      r.last = 1'b1;
      utf8_due_q.push_back(r);
    end
  endfunction

  function automatic void compare_field(string name, int want, int got);
    if (want != got) begin
      if (fail_cnt_o < 40)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_cnt_o++;
    end
  endfunction

  function automatic void check_result(logic [1:0] u, logic [15:0] d, logic last);
    utf8_result_t want;
    if (utf8_due_q.size() == 0) begin
      if (fail_cnt_o < 40)
        $display("%0t: unexpected result, expected none, actual tuser %0d tdata %04h tlast %0b",
                 $time, u, d, last);
      fail_cnt_o++;
    end else begin
      want = utf8_due_q.pop_front();
      compare_field("result_kind", want.kind, u);
      compare_field("out_byte", want.data, d[7:0]);
      compare_field("error_code", want.err, d[10:8]);
      compare_field("run_last", want.last, last);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      utf8_due_q.delete();
      fail_cnt_o = 0;
      pending_o <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) decode_text_byte(s_axis_tdata, s_axis_tuser[0]);
      if (m_axis_tvalid && m_axis_tready)
        check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
      pending_o <= utf8_due_q.size();
    end
  end

endmodule

// ----- bench/tb_json_string_unescape_utf8_unit.sv -----
// Testbench top for the JSON string unescape unit: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_json_string_unescape_utf8_unit;
  import jsu_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int RandomItems = 500;
  localparam int LongHold = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] in_byte
  logic [0:0]  s_axis_tuser = 1'b0;    // [0] text_end
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [7:0] out_byte, [10:8] error_code
  logic [1:0]  m_axis_tuser;           // [1:0] result_kind
  logic        m_axis_tlast;

  int fail_cnt;
  int pending;

  // Requests as {text_end, in_byte}
  logic [8:0] text_q[$];

  int sent_cnt = 0;
  int hold_at = -1;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int rx_idle_pct = 57;
  int cycle_cnt = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  json_string_unescape_utf8_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  jsu_result_checker result_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending)
  );

  task automatic push_byte(logic [7:0] b);
    text_q.push_back({1'b0, b});
  endtask

  // Byte lane carries noise alongside text end
  task automatic push_end();
    text_q.push_back({1'b1, 8'($urandom)});
  endtask

  task automatic push_text(string s);
    for (int k = 0; k < s.len(); k++) push_byte(s[k]);
  endtask

  // Push the top n_dig hex digits of v in random case; bad_pos picks one digit to spoil
  task automatic push_hex(logic [15:0] v, int n_dig, int bad_pos);
    logic [3:0] nib;
    logic [7:0] b;
    for (int k = 0; k < n_dig; k++) begin
      nib = 4'(v >> (12 - 4 * k));
      if (k == bad_pos) begin
        b = 8'($urandom);
        if ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
            (b >= 8'h61 && b <= 8'h66))
          b = 8'h7A;
      end else if (nib < 4'd10) begin
        b = 8'h30 + {4'h0, nib};
      end else begin
        b = ($urandom_range(0, 1) != 0 ? 8'h61 : 8'h41) + {4'h0, nib} - 8'd10;
      end
      push_byte(b);
    end
  endtask

  function automatic logic [15:0] rand_cp();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 'h7F));
      1: return 16'($urandom_range('h80, 'h7FF));
      2: return 16'($urandom_range('h800, 'hD7FF));
      3: return 16'($urandom_range('hE000, 'hFFFF));
      default: return 16'($urandom_range(LO_SUR_MIN, LO_SUR_MAX));
    endcase
  endfunction

  // One string literal, mostly well formed, sometimes preceded by a stray byte or broken off with an error
  task automatic gen_string();
    int          n_seg;
    int          corrupt_at;
    int          pick;
    int          n;
    logic [7:0]  b;
    logic [15:0] hi;
    if ($urandom_range(99) < 10) begin
      if ($urandom_range(0, 1) != 0) push_end();
      else push_byte(8'($urandom));
    end
    n_seg = int'($urandom_range(0, 6));
    corrupt_at = ($urandom_range(99) < 20) ? int'($urandom_range(0, n_seg)) : -1;
    push_byte(CH_QUOTE);
    for (int seg = 0; seg <= n_seg; seg++) begin
      hi = 16'($urandom_range(HI_SUR_MIN, HI_SUR_MAX));
      pick = int'($urandom_range(99));
      if (seg == corrupt_at) begin
        case ($urandom_range(0, 6))
          0: push_end();
          1: begin
            b = 8'($urandom);
            if (b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH || b == CH_B || b == CH_F ||
                b == CH_N || b == CH_R || b == CH_T || b == CH_U)
              b = 8'h71;
            push_byte(CH_BSLASH);
            push_byte(b);
          end
          2: begin
            push_byte(CH_BSLASH);
            push_end();
          end
          3: begin
            push_text("\\u");
            push_hex(rand_cp(), 4, int'($urandom_range(0, 3)));
          end
          4: begin
            push_text("\\u");
            n = int'($urandom_range(0, 3));
            push_hex(rand_cp(), n, ($urandom_range(0, 1) != 0) ? int'($urandom_range(0, 3)) : -1);
            push_end();
          end
          5: begin
            push_text("\\u");
            push_hex(hi, 4, -1);
            push_text("\\u");
            n = int'($urandom_range(0, 4));
            if (n == 4) begin
              push_hex(rand_cp(), 4, int'($urandom_range(0, 3)));
            end else begin
              push_hex(rand_cp(), n, -1);
              push_end();
            end
          end
          default: begin
            push_text("\\u");
            push_hex(hi, 4, -1);
            if ($urandom_range(0, 1) != 0) push_byte(CH_BSLASH);
            push_end();
          end
        endcase
        return;
      end
      if (seg == n_seg) begin
        push_byte(CH_QUOTE);
      end else if (pick < 30) begin
        do b = 8'($urandom); while (b == CH_QUOTE || b == CH_BSLASH);
        push_byte(b);
      end else if (pick < 50) begin
        case ($urandom_range(0, 7))
          0: b = CH_QUOTE;
          1: b = CH_BSLASH;
          2: b = CH_SLASH;
          3: b = CH_B;
          4: b = CH_F;
          5: b = CH_N;
          6: b = CH_R;
          default: b = CH_T;
        endcase
        push_byte(CH_BSLASH);
        push_byte(b);
      end else if (pick < 70) begin
        push_text("\\u");
        push_hex(rand_cp(), 4, -1);
      end else if (pick < 85) begin
        push_text("\\u");
        push_hex(hi, 4, -1);
        push_text("\\u");
        push_hex(16'($urandom_range(LO_SUR_MIN, LO_SUR_MAX)), 4, -1);
      end else begin
        // lone high surrogate; whatever follows decides the lookahead
        push_text("\\u");
        push_hex(hi, 4, -1);
      end
    end
  endtask

  task automatic send_item(logic [8:0] item, int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= item[7:0];
    s_axis_tuser  <= item[8];
    do @(posedge clk_i); while (!s_axis_tready);
    sent_cnt <= sent_cnt + 1;
  endtask

  // Receiver: random stalls, plus one long hold-off to back the block up
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && sent_cnt == hold_at) begin
      m_axis_tready <= 1'b0;
      hold_left <= LongHold;
      hold_done <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    int n_directed;
    int n_items;
    int tx_idle_pct;
    // stray text end and stray byte while waiting for a quote
    push_end();
    push_byte(8'h00);
    // raw extremes, then a bad escape
    push_byte(CH_QUOTE);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(CH_BSLASH);
    push_byte(8'h71);
    // text end right after a backslash
    push_byte(CH_QUOTE);
    push_byte(CH_BSLASH);
    push_end();
    // text end inside \u after a bad digit is still truncation
    push_text("\"\\uz");
    push_end();
    // held high surrogate flushed ahead of a three-byte character, then close
    push_text("\"\\uDBFF\\u0800\"");
    n_directed = text_q.size();
    while (text_q.size() < n_directed + RandomItems) gen_string();
    n_items = text_q.size();
    hold_at = (2 * n_items) / 3 + 40;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int k = 0; k < n_items; k++) begin
      if (k == n_items / 3 || k == (2 * n_items) / 3) begin
        // drain before switching the flow-control pattern
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (pending != 0);
        rx_idle_pct <= (k == n_items / 3) ? 33 : 0;
      end
      tx_idle_pct = (k < n_items / 3) ? 33 : (k < (2 * n_items) / 3) ? 57 : 0;
      send_item(text_q[k], tx_idle_pct);
    end
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
